// File: src/rrts_pkg.sv
// Shared types and constants of the round-robin task scheduler.
`default_nettype none
package rrts_pkg;

  typedef enum logic [3:0] {
    CMD_ADD         = 4'd0,
    CMD_SET_BLOCK   = 4'd1,
    CMD_TICK        = 4'd2,
    CMD_CHECK_TICK  = 4'd3,
    CMD_SCHEDULE    = 4'd4,
    CMD_EXIT        = 4'd5,
    CMD_WAKE_READER = 4'd6,
    CMD_WAKE_WRITER = 4'd7,
    CMD_FIND_WRITER = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_LAST_TASK = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ROT_RD,
    S_ROT_WR,
    S_FIN,
    S_RESP
  } state_e;

  localparam logic [2:0] TERM_NONE = 3'b111;
  localparam logic [16:0] NO_TICK_PID = 17'h1FFFF;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] delay;
    logic        waiting;
    logic [2:0]  rt;
    logic [2:0]  wt;
    logic [2:0]  wrt;
    logic [2:0]  wwt;
  } task_entry_t;

  function automatic logic is_blocked(input task_entry_t t);
    return (t.delay != 16'd0) || t.waiting || (t.rt != TERM_NONE) ||
           (t.wt != TERM_NONE) || (t.wrt != TERM_NONE) || (t.wwt != TERM_NONE);
  endfunction

endpackage
`default_nettype wire

// File: src/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: ring memory and command sequencer.
`default_nettype none
// The scheduler keeps its task entries in one ring memory of MAX_TASKS entries with a
// registered read, and runs one command at a time; every command gives exactly one result
// transfer. Add, check_tick and unused codes pass from idle through the finish and
// response states to the output register. Set_block, tick, wake and find walk the ring
// from the head, one entry read per cycle with the write-back of the entry before it in
// the same cycle; set_block, wake and find stop early at the first match. Schedule walks
// the same way until the first runnable task after the head (or the head itself while
// idle), then moves each entry it passed to the tail through a read state and a write
// state; exit reads only the head. A new input transfer is taken while the previous result
// still waits in the output register. The idle pid must be written through the configuration
// port only while no command is in flight; the block itself does not enforce this.
module round_robin_task_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int NUM_TERMS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [3:0]         cmd_i,
  input  wire logic [15:0]        pid_i,
  input  wire logic [15:0]        delay_i,
  input  wire logic               waiting_i,
  input  wire logic signed [2:0]  read_term_i,
  input  wire logic signed [2:0]  write_term_i,
  input  wire logic signed [2:0]  wait_read_term_i,
  input  wire logic signed [2:0]  wait_write_term_i,
  input  wire logic [1:0]         term_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [15:0]        running_pid_o,
  output      logic               idle_running_o,
  output      logic               switched_o,
  output      logic [15:0]        from_pid_o,
  output      logic               any_zeroed_o,
  output      logic               same_as_last_o,
  output      logic [15:0]        found_pid_o,
  output      logic [2:0]         status_o
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int SW = IW + 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TASKS);
  localparam logic [SW-1:0] RING_SIZE = SW'(MAX_TASKS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

  // Ring position i from the head, wrapped into the memory range.
  function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = {1'b0, base} + SW'(off);
    if (sum >= RING_SIZE) begin
      sum = sum - RING_SIZE;
    end
    return sum[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : IW'(idx + 1'b1);
  endfunction

  function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] idx);
    return (idx == '0) ? LAST_IDX : IW'(idx - 1'b1);
  endfunction

  // Ring memory.
  rrts_pkg::task_entry_t ring_mem [MAX_TASKS];
  rrts_pkg::task_entry_t rdata_q;
  logic [IW-1:0]         raddr;
  logic                  we;
  logic [IW-1:0]         waddr;
  rrts_pkg::task_entry_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      ring_mem[waddr] <= wdata;
    end
    rdata_q <= ring_mem[raddr];
  end

  // Control and architectural state.
  rrts_pkg::state_e      state_q, state_d;
  logic [IW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  idle_q, idle_d;
  logic [16:0]           last_q, last_d;
  logic [15:0]           idle_pid_q;
  rrts_pkg::cmd_e        cmd_q, cmd_d;
  rrts_pkg::task_entry_t in_q;
  logic [1:0]            term_q;
  logic [CW-1:0]         rd_idx_q, rd_idx_d;
  logic                  pend_q, pend_d;
  logic [CW-1:0]         pend_idx_q, pend_idx_d;
  logic [CW-1:0]         lim_q, lim_d;
  logic [CW-1:0]         k_q, k_d;
  logic [CW-1:0]         rot_q, rot_d;
  logic                  b0_q, b0_d;
  logic [15:0]           pid0_q, pid0_d;
  logic                  sw_q, sw_d;
  logic [15:0]           from_q, from_d;
  logic                  zero_q, zero_d;
  logic [15:0]           found_q, found_d;
  rrts_pkg::status_e     status_q, status_d;
  logic                  out_valid_q;
  logic [15:0]           o_run_q;
  logic                  o_idle_q, o_sw_q, o_zero_q, o_same_q;
  logic [15:0]           o_from_q, o_found_q;
  logic [2:0]            o_status_q;

  logic                  in_xfer;
  rrts_pkg::cmd_e        cmd_in;
  rrts_pkg::task_entry_t in_entry;
  logic                  term_ok;

  assign in_stall_o = (state_q != rrts_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cmd_in     = rrts_pkg::cmd_e'(cmd_i);
  assign term_ok    = (32'(term_i) < NUM_TERMS);

  always_comb begin
    in_entry.pid     = pid_i;
    in_entry.delay   = delay_i;
    in_entry.waiting = waiting_i;
    in_entry.rt      = $unsigned(read_term_i);
    in_entry.wt      = $unsigned(write_term_i);
    in_entry.wrt     = $unsigned(wait_read_term_i);
    in_entry.wwt     = $unsigned(wait_write_term_i);
  end

  // Evaluation of the entry that arrives from memory during a walk.
  rrts_pkg::task_entry_t d;
  logic                  d_blk, hit, last_one, scan_done, load_out;
  logic [2:0]            term_x;
  logic                  b0_now;
  logic [15:0]           pid0_now, run_pid;

  assign d        = rdata_q;
  assign d_blk    = rrts_pkg::is_blocked(d);
  assign term_x   = {1'b0, term_q};
  assign last_one = (CW'(pend_idx_q + 1'b1) == lim_q);
  assign b0_now   = (pend_idx_q == '0) ? d_blk : b0_q;
  assign pid0_now = (pend_idx_q == '0) ? d.pid : pid0_q;

  always_comb begin
    case (cmd_q)
      rrts_pkg::CMD_SET_BLOCK:   hit = (d.pid == in_q.pid);
      rrts_pkg::CMD_WAKE_READER: hit = (d.wrt == term_x);
      rrts_pkg::CMD_WAKE_WRITER: hit = (d.wwt == term_x);
      rrts_pkg::CMD_FIND_WRITER: hit = (d.wt == term_x);
      rrts_pkg::CMD_SCHEDULE:    hit = !d_blk && ((pend_idx_q != '0) || idle_q);
      rrts_pkg::CMD_EXIT:        hit = 1'b1;
      default:                   hit = 1'b0;
    endcase
  end

  assign scan_done = (state_q == rrts_pkg::S_SCAN) && pend_q && (hit || last_one);
  assign load_out  = (state_q == rrts_pkg::S_RESP) && (!out_valid_q || !out_stall_i);
  assign run_pid   = (idle_q || (count_q == '0)) ? idle_pid_q : rdata_q.pid;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrts_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (cmd_in)
            rrts_pkg::CMD_SET_BLOCK, rrts_pkg::CMD_TICK, rrts_pkg::CMD_SCHEDULE: begin
              state_d = (count_q == '0) ? rrts_pkg::S_FIN : rrts_pkg::S_SCAN;
            end
            rrts_pkg::CMD_WAKE_READER, rrts_pkg::CMD_WAKE_WRITER,
            rrts_pkg::CMD_FIND_WRITER: begin
              state_d = ((count_q == '0) || !term_ok) ? rrts_pkg::S_FIN : rrts_pkg::S_SCAN;
            end
            rrts_pkg::CMD_EXIT: begin
              state_d = (count_q > CW'(1)) ? rrts_pkg::S_SCAN : rrts_pkg::S_FIN;
            end
            default: state_d = rrts_pkg::S_FIN;
          endcase
        end
      end
      rrts_pkg::S_SCAN: begin
        if (scan_done) begin
          if (cmd_q == rrts_pkg::CMD_SCHEDULE && hit && pend_idx_q != '0) begin
            state_d = rrts_pkg::S_ROT_RD;
          end else begin
            state_d = rrts_pkg::S_FIN;
          end
        end
      end
      rrts_pkg::S_ROT_RD: state_d = rrts_pkg::S_ROT_WR;
      rrts_pkg::S_ROT_WR: begin
        state_d = (CW'(rot_q + 1'b1) == k_q) ? rrts_pkg::S_FIN : rrts_pkg::S_ROT_RD;
      end
      rrts_pkg::S_FIN:  state_d = rrts_pkg::S_RESP;
      rrts_pkg::S_RESP: begin
        if (load_out) begin
          state_d = rrts_pkg::S_IDLE;
        end
      end
      default: state_d = rrts_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory port and result values.
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    idle_d     = idle_q;
    last_d     = last_q;
    cmd_d      = cmd_q;
    rd_idx_d   = rd_idx_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    lim_d      = lim_q;
    k_d        = k_q;
    rot_d      = rot_q;
    b0_d       = b0_q;
    pid0_d     = pid0_q;
    sw_d       = sw_q;
    from_d     = from_q;
    zero_d     = zero_q;
    found_d    = found_q;
    status_d   = status_q;
    raddr      = head_q;
    we         = 1'b0;
    waddr      = ring_slot(head_q, pend_idx_q);
    wdata      = d;
    case (state_q)
      rrts_pkg::S_IDLE: begin
        if (in_xfer) begin
          cmd_d    = cmd_in;
          rd_idx_d = '0;
          lim_d    = count_q;
          sw_d     = 1'b0;
          from_d   = '0;
          zero_d   = 1'b0;
          found_d  = '0;
          status_d = rrts_pkg::ST_OK;
          case (cmd_in)
            rrts_pkg::CMD_ADD: begin
              if (count_q == FULL_COUNT) begin
                status_d = rrts_pkg::ST_FULL;
              end else begin
                head_d  = ring_dec(head_q);
                we      = 1'b1;
                waddr   = ring_dec(head_q);
                wdata   = in_entry;
                count_d = CW'(count_q + 1'b1);
              end
            end
            rrts_pkg::CMD_SET_BLOCK, rrts_pkg::CMD_WAKE_READER,
            rrts_pkg::CMD_WAKE_WRITER, rrts_pkg::CMD_FIND_WRITER: begin
              status_d = rrts_pkg::ST_NOT_FOUND;
            end
            rrts_pkg::CMD_CHECK_TICK: begin
              if (!idle_q && count_q == '0) begin
                status_d = rrts_pkg::ST_EMPTY;
              end
            end
            rrts_pkg::CMD_SCHEDULE: begin
              if (count_q == '0) begin
                status_d = rrts_pkg::ST_EMPTY;
              end
            end
            rrts_pkg::CMD_EXIT: begin
              lim_d = CW'(1);
              if (count_q == '0) begin
                status_d = rrts_pkg::ST_EMPTY;
              end else if (count_q == CW'(1)) begin
                status_d = rrts_pkg::ST_LAST_TASK;
              end
            end
            default: ;
          endcase
        end
      end
      rrts_pkg::S_SCAN: begin
        raddr = ring_slot(head_q, rd_idx_q);
        if (rd_idx_q < lim_q) begin
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q;
          rd_idx_d   = CW'(rd_idx_q + 1'b1);
        end
        if (pend_q) begin
          case (cmd_q)
            rrts_pkg::CMD_TICK: begin
              if (d.delay != 16'd0) begin
                we          = 1'b1;
                wdata.delay = d.delay - 16'd1;
                if (d.delay == 16'd1) begin
                  zero_d = 1'b1;
                end
              end
            end
            rrts_pkg::CMD_SET_BLOCK: begin
              if (hit) begin
                we       = 1'b1;
                wdata    = in_q;
                status_d = rrts_pkg::ST_OK;
              end
            end
            rrts_pkg::CMD_WAKE_READER: begin
              if (hit) begin
                we        = 1'b1;
                wdata.wrt = rrts_pkg::TERM_NONE;
                status_d  = rrts_pkg::ST_OK;
              end
            end
            rrts_pkg::CMD_WAKE_WRITER: begin
              if (hit) begin
                we        = 1'b1;
                wdata.wwt = rrts_pkg::TERM_NONE;
                status_d  = rrts_pkg::ST_OK;
              end
            end
            rrts_pkg::CMD_FIND_WRITER: begin
              if (hit) begin
                found_d  = d.pid;
                status_d = rrts_pkg::ST_OK;
              end
            end
            rrts_pkg::CMD_EXIT: begin
              from_d  = d.pid;
              head_d  = ring_inc(head_q);
              count_d = CW'(count_q - 1'b1);
              idle_d  = 1'b1;
              last_d  = '0;
              sw_d    = 1'b1;
            end
            rrts_pkg::CMD_SCHEDULE: begin
              b0_d   = b0_now;
              pid0_d = pid0_now;
              if (hit && pend_idx_q == '0) begin
                // The head task can run again: leave the idle task.
                idle_d = 1'b0;
                sw_d   = 1'b1;
                from_d = idle_pid_q;
              end else if (hit) begin
                // Rotate the entries ahead of the runnable task to the tail.
                k_d    = pend_idx_q;
                rot_d  = '0;
                from_d = idle_q ? idle_pid_q : pid0_q;
                idle_d = 1'b0;
                sw_d   = 1'b1;
              end else if (last_one && !idle_q && b0_now) begin
                from_d = pid0_now;
                idle_d = 1'b1;
                sw_d   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      rrts_pkg::S_ROT_WR: begin
        we     = 1'b1;
        waddr  = ring_slot(head_q, count_q);
        wdata  = rdata_q;
        head_d = ring_inc(head_q);
        rot_d  = CW'(rot_q + 1'b1);
      end
      rrts_pkg::S_RESP: begin
        if (load_out && cmd_q == rrts_pkg::CMD_CHECK_TICK &&
            status_q == rrts_pkg::ST_OK) begin
          last_d = {1'b0, run_pid};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrts_pkg::S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idle_q      <= 1'b0;
      last_q      <= rrts_pkg::NO_TICK_PID;
      idle_pid_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idle_q  <= idle_d;
      last_q  <= last_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        idle_pid_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_idx_q   <= rd_idx_d;
    pend_idx_q <= pend_idx_d;
    lim_q      <= lim_d;
    k_q        <= k_d;
    rot_q      <= rot_d;
    b0_q       <= b0_d;
    pid0_q     <= pid0_d;
    sw_q       <= sw_d;
    from_q     <= from_d;
    zero_q     <= zero_d;
    found_q    <= found_d;
    status_q   <= status_d;
    if (in_xfer) begin
      in_q   <= in_entry;
      term_q <= term_i;
    end
    if (load_out) begin
      o_run_q    <= run_pid;
      o_idle_q   <= idle_q;
      o_sw_q     <= sw_q;
      o_from_q   <= from_q;
      o_zero_q   <= zero_q;
      o_same_q   <= (cmd_q == rrts_pkg::CMD_CHECK_TICK) &&
                    (status_q == rrts_pkg::ST_OK) && (last_q == {1'b0, run_pid});
      o_found_q  <= found_q;
      o_status_q <= status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_pid_o  = o_run_q;
  assign idle_running_o = o_idle_q;
  assign switched_o     = o_sw_q;
  assign from_pid_o     = o_from_q;
  assign any_zeroed_o   = o_zero_q;
  assign same_as_last_o = o_same_q;
  assign found_pid_o    = o_found_q;
  assign status_o       = o_status_q;

endmodule
`default_nettype wire

// File: src/rrts_checker.sv
// Port-level checks of the round-robin task scheduler, bound to the top level.
`default_nettype none
module rrts_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        switched_o,
  input wire logic        any_zeroed_o,
  input wire logic        same_as_last_o,
  input wire logic [15:0] found_pid_o,
  input wire logic [2:0]  status_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A context switch only comes with a good status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && switched_o |-> status_o == rrts_pkg::ST_OK)
    else $error("switch reported with error status");

  // Tick, check and find flags belong to different commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (any_zeroed_o || same_as_last_o) |->
      !switched_o && found_pid_o == 16'd0 && !(any_zeroed_o && same_as_last_o))
    else $error("flags of different commands in one result");

  // After an input transfer the block is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer taken while busy");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .switched_o     (switched_o),
  .any_zeroed_o   (any_zeroed_o),
  .same_as_last_o (same_as_last_o),
  .found_pid_o    (found_pid_o),
  .status_o       (status_o)
);
`default_nettype wire

// File: bench/round_robin_task_scheduler_test.sv
// Self-checking testbench of the round-robin task scheduler.
`timescale 1ns / 1ps
module round_robin_task_scheduler_test;

  localparam int RING_DEPTH = 16;
  localparam int TERM_COUNT = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] TERM_NONE = rrts_pkg::TERM_NONE;

  // One command as the sender drives it.
  typedef struct {
    logic [3:0]  cmd;
    logic [15:0] pid;
    logic [15:0] delay;
    logic        waiting;
    logic [2:0]  rt, wt, wrt, wwt;
    logic [1:0]  term;
  } sched_cmd_t;

  // One result of the block.
  typedef struct {
    logic [15:0] running_pid;
    logic        idle_running;
    logic        switched;
    logic [15:0] from_pid;
    logic        any_zeroed;
    logic        same_as_last;
    logic [15:0] found_pid;
    logic [2:0]  status;
  } sched_result_t;

  // The scoreboard keeps its own image of the task ring and predicts one result
  // for every command transfer.
  class sched_scoreboard;
    rrts_pkg::task_entry_t ring[RING_DEPTH];
    int unsigned head, count;
    bit idle;
    logic [16:0] last_tick;
    logic [15:0] idle_pid;
    sched_result_t pending_results[$];
    int mismatches;

    function void clear();
      head = 0; count = 0; idle = 0; last_tick = rrts_pkg::NO_TICK_PID; idle_pid = 0;
      mismatches = 0;
    endfunction

    function int unsigned slot_of(int unsigned i);
      return (head + i) % RING_DEPTH;
    endfunction

    function bit blocked(rrts_pkg::task_entry_t t);
      return t.delay != 0 || t.waiting || t.rt != TERM_NONE || t.wt != TERM_NONE ||
             t.wrt != TERM_NONE || t.wwt != TERM_NONE;
    endfunction

    function logic [15:0] current_pid();
      if (idle || count == 0) return idle_pid;
      return ring[head].pid;
    endfunction

    function rrts_pkg::task_entry_t entry_from(sched_cmd_t c);
      rrts_pkg::task_entry_t t;
      t.pid = c.pid; t.delay = c.delay; t.waiting = c.waiting;
      t.rt = c.rt; t.wt = c.wt; t.wrt = c.wrt; t.wwt = c.wwt;
      return t;
    endfunction

    // Applies one accepted command and queues the result it must give.
    function void note_command(sched_cmd_t c);
      sched_result_t r;
      int unsigned k, i, s;
      r = '{default: '0};
      case (c.cmd)
        rrts_pkg::CMD_ADD: begin
          if (count >= RING_DEPTH) r.status = rrts_pkg::ST_FULL;
          else begin
            head = (head + RING_DEPTH - 1) % RING_DEPTH;
            ring[head] = entry_from(c);
            count++;
          end
        end
        rrts_pkg::CMD_SET_BLOCK: begin
          r.status = rrts_pkg::ST_NOT_FOUND;
          for (i = 0; i < count; i++) begin
            if (ring[slot_of(i)].pid == c.pid) begin
              ring[slot_of(i)] = entry_from(c);
              r.status = rrts_pkg::ST_OK;
              break;
            end
          end
        end
        rrts_pkg::CMD_TICK: begin
          for (i = 0; i < count; i++) begin
            s = slot_of(i);
            if (ring[s].delay != 0) begin
              ring[s].delay--;
              if (ring[s].delay == 0) r.any_zeroed = 1;
            end
          end
        end
        rrts_pkg::CMD_CHECK_TICK: begin
          if (!idle && count == 0) r.status = rrts_pkg::ST_EMPTY;
          else begin
            r.same_as_last = (last_tick == {1'b0, current_pid()});
            last_tick = {1'b0, current_pid()};
          end
        end
        rrts_pkg::CMD_SCHEDULE: begin
          k = 0;
          if (count == 0) r.status = rrts_pkg::ST_EMPTY;
          else if (idle && !blocked(ring[head])) begin
            // The head became runnable while the idle task ran.
            idle = 0; r.switched = 1; r.from_pid = idle_pid;
          end else begin
            for (i = 1; i < count; i++) begin
              if (!blocked(ring[slot_of(i)])) begin
                k = i;
                break;
              end
            end
            if (k == 0) begin
              if (!idle && blocked(ring[head])) begin
                r.from_pid = ring[head].pid; idle = 1; r.switched = 1;
              end
            end else begin
              r.from_pid = current_pid();
              for (i = 0; i < k; i++) begin
                ring[slot_of(count)] = ring[head];
                head = (head + 1) % RING_DEPTH;
              end
              idle = 0; r.switched = 1;
            end
          end
        end
        rrts_pkg::CMD_EXIT: begin
          if (count == 0) r.status = rrts_pkg::ST_EMPTY;
          else if (count == 1) r.status = rrts_pkg::ST_LAST_TASK;
          else begin
            r.from_pid = ring[head].pid;
            head = (head + 1) % RING_DEPTH;
            count--; idle = 1; last_tick = '0; r.switched = 1;
          end
        end
        rrts_pkg::CMD_WAKE_READER, rrts_pkg::CMD_WAKE_WRITER: begin
          r.status = rrts_pkg::ST_NOT_FOUND;
          if (c.term < TERM_COUNT) begin
            for (i = 0; i < count; i++) begin
              s = slot_of(i);
              if (c.cmd == rrts_pkg::CMD_WAKE_READER && ring[s].wrt == {1'b0, c.term}) begin
                ring[s].wrt = TERM_NONE; r.status = rrts_pkg::ST_OK;
                break;
              end
              if (c.cmd == rrts_pkg::CMD_WAKE_WRITER && ring[s].wwt == {1'b0, c.term}) begin
                ring[s].wwt = TERM_NONE; r.status = rrts_pkg::ST_OK;
                break;
              end
            end
          end
        end
        rrts_pkg::CMD_FIND_WRITER: begin
          r.status = rrts_pkg::ST_NOT_FOUND;
          if (c.term < TERM_COUNT) begin
            for (i = 0; i < count; i++) begin
              if (ring[slot_of(i)].wt == {1'b0, c.term}) begin
                r.found_pid = ring[slot_of(i)].pid; r.status = rrts_pkg::ST_OK;
                break;
              end
            end
          end
        end
        default: ;
      endcase
      r.running_pid = current_pid();
      r.idle_running = idle;
      pending_results.push_back(r);
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_result(sched_result_t got);
      sched_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.running_pid !== want.running_pid || got.idle_running !== want.idle_running ||
          got.switched !== want.switched || got.from_pid !== want.from_pid ||
          got.any_zeroed !== want.any_zeroed || got.same_as_last !== want.same_as_last ||
          got.found_pid !== want.found_pid || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] cmd_i = '0;
  logic [15:0] pid_i = '0, delay_i = '0;
  logic waiting_i = 1'b0;
  logic signed [2:0] read_term_i = '1, write_term_i = '1;
  logic signed [2:0] wait_read_term_i = '1, wait_write_term_i = '1;
  logic [1:0] term_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] running_pid_o, from_pid_o, found_pid_o;
  logic idle_running_o, switched_o, any_zeroed_o, same_as_last_o;
  logic [2:0] status_o;

  sched_scoreboard board = new();
  int unsigned cycle_count = 0;
  bit calm_phase = 0;      // no idling on either side near the end
  int unsigned hold_off = 0; // requested long receiver stall, in cycles

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  round_robin_task_scheduler DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .cmd_i, .pid_i, .delay_i, .waiting_i, .read_term_i, .write_term_i,
    .wait_read_term_i, .wait_write_term_i, .term_i, .out_valid_o, .out_stall_i,
    .running_pid_o, .idle_running_o, .switched_o, .from_pid_o, .any_zeroed_o,
    .same_as_last_o, .found_pid_o, .status_o
  );

  // The watchdog ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Results are sampled at the clock edge, before the nonblocking updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result('{running_pid_o, idle_running_o, switched_o, from_pid_o,
                           any_zeroed_o, same_as_last_o, found_pid_o, status_o});
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned burst;
    @(posedge rst_ni);
    forever begin
      if (hold_off > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Offers one command and returns once the transfer has taken place. Valid
  // stays high from one command to the next when no gap follows.
  task automatic send_command(sched_cmd_t c);
    int unsigned gap;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c.cmd; pid_i <= c.pid; delay_i <= c.delay; waiting_i <= c.waiting;
    read_term_i <= c.rt; write_term_i <= c.wt;
    wait_read_term_i <= c.wrt; wait_write_term_i <= c.wwt; term_i <= c.term;
    do @(posedge clk_i); while (in_stall_o);
    board.note_command(c);
  endtask

  // Drops valid and waits until every expected result has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_idle_pid(logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.idle_pid = value;
  endtask

  function automatic sched_cmd_t make_cmd(logic [3:0] op, logic [15:0] pid,
                                          logic [15:0] delay, logic waiting,
                                          logic [2:0] rt, logic [2:0] wt,
                                          logic [2:0] wrt, logic [2:0] wwt,
                                          logic [1:0] term);
    sched_cmd_t c;
    c.cmd = op; c.pid = pid; c.delay = delay; c.waiting = waiting;
    c.rt = rt; c.wt = wt; c.wrt = wrt; c.wwt = wwt; c.term = term;
    return c;
  endfunction

  // Tasks with mostly small delays and random blocking fields, so that schedule and tick have work;
  // pids come from a narrow pool so that set_block and duplicates find matches.
  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int unsigned pick;
    c.pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24));
    c.delay = ($urandom_range(0, 1) == 0) ? 16'd0 :
              (($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4)));
    c.waiting = ($urandom_range(0, 5) == 0);
    c.rt = ($urandom_range(0, 4) == 0) ? 3'($urandom) : TERM_NONE;
    c.wt = ($urandom_range(0, 3) == 0) ? 3'($urandom) : TERM_NONE;
    c.wrt = ($urandom_range(0, 3) == 0) ? 3'($urandom) : TERM_NONE;
    c.wwt = ($urandom_range(0, 3) == 0) ? 3'($urandom) : TERM_NONE;
    c.term = 2'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 18) c.cmd = rrts_pkg::CMD_ADD;
    else if (pick < 28) c.cmd = rrts_pkg::CMD_SET_BLOCK;
    else if (pick < 43) c.cmd = rrts_pkg::CMD_TICK;
    else if (pick < 51) c.cmd = rrts_pkg::CMD_CHECK_TICK;
    else if (pick < 71) c.cmd = rrts_pkg::CMD_SCHEDULE;
    else if (pick < 78) c.cmd = rrts_pkg::CMD_EXIT;
    else if (pick < 85) c.cmd = rrts_pkg::CMD_WAKE_READER;
    else if (pick < 92) c.cmd = rrts_pkg::CMD_WAKE_WRITER;
    else if (pick < 98) c.cmd = rrts_pkg::CMD_FIND_WRITER;
    else c.cmd = 4'($urandom_range(9, 15));
    return c;
  endfunction

  initial begin
    int i;
    board.clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_idle_pid(16'hFFFF);

    // Directed part: empty-ring errors, a full ring, every command and the
    // field extremes.
    send_command(make_cmd(rrts_pkg::CMD_SCHEDULE, 0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 0));
    send_command(make_cmd(rrts_pkg::CMD_EXIT, 0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 0));
    send_command(make_cmd(rrts_pkg::CMD_CHECK_TICK, 0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 0));
    send_command(make_cmd(rrts_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 1, 3'd3, 3'd3, 3'd3,
                          3'd3, 3));
    send_command(make_cmd(rrts_pkg::CMD_EXIT, 0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 0));
    for (i = 1; i < RING_DEPTH; i++)
      send_command(make_cmd(rrts_pkg::CMD_ADD, 16'(i), 16'(i % 3), 0, TERM_NONE,
                            TERM_NONE, (i == 5) ? 3'd2 : TERM_NONE, 3'b100, 0));
    send_command(make_cmd(rrts_pkg::CMD_ADD, 16'h0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 0));
    send_command(make_cmd(rrts_pkg::CMD_SET_BLOCK, 16'hBEEF, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 0));
    send_command(make_cmd(rrts_pkg::CMD_TICK, 0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 0));
    send_command(make_cmd(rrts_pkg::CMD_SCHEDULE, 0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 0));
    send_command(make_cmd(rrts_pkg::CMD_WAKE_READER, 0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 2));
    send_command(make_cmd(rrts_pkg::CMD_WAKE_WRITER, 0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 0));
    send_command(make_cmd(rrts_pkg::CMD_FIND_WRITER, 0, 0, 0, TERM_NONE, TERM_NONE,
                          TERM_NONE, TERM_NONE, 3));
    send_command(make_cmd(4'd15, 0, 0, 0, TERM_NONE, TERM_NONE, TERM_NONE, TERM_NONE, 0));

    // The receiver holds off while the sender keeps offering, so the block backs up.
    hold_off = 200;
    for (i = 0; i < 12; i++) send_command(random_cmd());
    drain();
    write_idle_pid(16'h0000);

    for (i = 0; i < 500; i++) begin
      if (i == 150) begin
        drain();
        write_idle_pid(16'($urandom));
      end
      if (i == 300) begin
        drain();
        write_idle_pid(16'h8001);
      end
      if (i == 420) calm_phase = 1;
      send_command(random_cmd());
    end
    drain();

    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
